// ----- hw/rtl/led_seq_pkg.sv -----
// Package for the LED action sequencer: action codes, register indexes,
// item kinds and the structs passed between the sequencer modules.
// No dependencies.
`default_nettype none

package led_seq_pkg;

    localparam int EVENT_CODES = 8;

    localparam logic [3:0] ACT_NONE   = 4'd0;
    localparam logic [3:0] ACT_OFF    = 4'd1;
    localparam logic [3:0] ACT_ON     = 4'd2;
    localparam logic [3:0] ACT_TOGGLE = 4'd3;
    localparam logic [3:0] ACT_PULSE  = 4'd4;
    localparam logic [3:0] ACT_BLINK1 = 4'd5;
    localparam logic [3:0] ACT_BLINK8 = 4'd12;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_TRIGGER = 1'b1;

    localparam logic [1:0] REG_GREEN_EVENT  = 2'd0;
    localparam logic [1:0] REG_RED_EVENT    = 2'd1;
    localparam logic [1:0] REG_BLINK_DIVIDE = 2'd2;

    typedef struct packed {
        logic [3:0] pending;
        logic       level;
    } led_state_t;

    typedef struct packed {
        logic red_busy;
        logic green_busy;
        logic red_led;
        logic green_led;
    } led_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/led_action_sequencer.sv -----
// Top level of the LED action sequencer: input register, configuration
// registers, result register. Depends on led_seq_pkg and led_seq_core.
//
//   channel  dir  handshake           payload
//   s_       in   s_tvalid/s_tready   s_tdata event_code, new_action; s_tuser kind
//   m_       out  m_tvalid/m_tready   m_tdata green_led, red_led, green_busy, red_busy
//   cfg_     in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// An item is held in the input register and is applied to the LED state while
// moving into the result register, where its result is offered until it is taken.
// One item per cycle is sustained while the output takes results; the result register
// and input register together let the input take a new item while a result waits.
// Reset clears the LED state, prescaler, configuration registers and valid flags
// to their idle values; the data registers are not reset.
// A stalled output holds the result and then the input register in place.
`default_nettype none

module led_action_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [2:0] event_code, [6:3] new_action, [7] zero
    input  logic [0:0] s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] green_led, [1] red_led, [2] green_busy,
                                  // [3] red_busy, [7:4] zero
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import led_seq_pkg::*;

    logic        in_valid_reg;
    logic        in_kind_reg;
    logic [2:0]  in_event_reg;
    logic [3:0]  in_action_reg;
    logic        out_valid_reg;
    led_status_t out_status_reg;
    logic [2:0]  green_event_reg;
    logic [2:0]  red_event_reg;
    logic [7:0]  blink_divide_reg;

    logic        advance;
    logic        item_en;
    led_status_t status_cur;
    led_status_t status_next;

    assign advance   = !out_valid_reg || m_tready;
    assign item_en   = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_kind_reg   <= s_tuser[0];
            in_event_reg  <= s_tdata[2:0];
            in_action_reg <= s_tdata[6:3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_event_reg  <= 3'd0;
            red_event_reg    <= 3'd0;
            blink_divide_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GREEN_EVENT:  green_event_reg  <= cfg_data[2:0];
                REG_RED_EVENT:    red_event_reg    <= cfg_data[2:0];
                REG_BLINK_DIVIDE: blink_divide_reg <= cfg_data;
                default:          blink_divide_reg <= blink_divide_reg;
            endcase
        end
    end

    led_seq_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_en      (item_en),
        .kind         (in_kind_reg),
        .event_code   (in_event_reg),
        .new_action   (in_action_reg),
        .green_event  (green_event_reg),
        .red_event    (red_event_reg),
        .blink_divide (blink_divide_reg),
        .status_cur   (status_cur),
        .status_next  (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_en)
        begin
            out_status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_status_reg.red_busy, out_status_reg.green_busy,
                       out_status_reg.red_led, out_status_reg.green_led};

    // The input side stalls only when both stages hold an item and the output is blocked.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled while the pipeline had room");

    // A processed item always lands in the result register.
    a_item_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        item_en |=> out_valid_reg)
        else $error("processed item did not produce a result");

    // A waiting result always reflects the current LED state.
    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == status_cur))
        else $error("result register differs from LED state");

endmodule

`default_nettype wire

// ----- hw/rtl/led_seq_led.sv -----
// Single-LED step logic: applies one tick to a pending action and level,
// including the shared blink prescaler. Depends on led_seq_pkg.
`default_nettype none

module led_seq_led (
    input  led_seq_pkg::led_state_t state_cur,
    input  logic [7:0]              count_in,
    input  logic [7:0]              blink_divide,
    output led_seq_pkg::led_state_t state_next,
    output logic [7:0]              count_out
);
    import led_seq_pkg::*;

    logic [7:0] count_inc;

    assign count_inc = count_in + 8'd1;

    always_comb
    begin
        state_next = state_cur;
        count_out  = count_in;
        case (state_cur.pending)
            ACT_NONE:
            begin
                state_next = state_cur;
            end
            ACT_OFF:
            begin
                state_next.level   = 1'b0;
                state_next.pending = ACT_NONE;
            end
            ACT_ON:
            begin
                state_next.level   = 1'b1;
                state_next.pending = ACT_NONE;
            end
            ACT_TOGGLE:
            begin
                state_next.level   = ~state_cur.level;
                state_next.pending = ACT_NONE;
            end
            ACT_PULSE:
            begin
                state_next.level = ~state_cur.level;
                if (state_cur.level)
                begin
                    state_next.pending = ACT_NONE;
                end
            end
            default:
            begin
                if (state_cur.pending >= ACT_BLINK1 && state_cur.pending <= ACT_BLINK8)
                begin
                    count_out = count_inc;
                    if (count_inc == blink_divide)
                    begin
                        count_out        = 8'd0;
                        state_next.level = ~state_cur.level;
                        if (state_cur.level)
                        begin
                            if (state_cur.pending == ACT_BLINK1)
                            begin
                                state_next.pending = ACT_NONE;
                            end
                            else
                            begin
                                state_next.pending = state_cur.pending - 4'd1;
                            end
                        end
                    end
                end
                else
                begin
                    // Unknown codes are dropped without touching the level.
                    state_next.pending = ACT_NONE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/led_seq_core.sv -----
// LED state registers and per-item update: trigger matching and the
// red-then-green tick chain. Depends on led_seq_pkg and led_seq_led.
`default_nettype none

module led_seq_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_en,
    input  logic                     kind,
    input  logic [2:0]               event_code,
    input  logic [3:0]               new_action,
    input  logic [2:0]               green_event,
    input  logic [2:0]               red_event,
    input  logic [7:0]               blink_divide,
    output led_seq_pkg::led_status_t status_cur,
    output led_seq_pkg::led_status_t status_next
);
    import led_seq_pkg::*;

    led_state_t red_reg;
    led_state_t red_next;
    led_state_t green_reg;
    led_state_t green_next;
    logic [7:0] count_reg;
    logic [7:0] count_next;

    led_state_t red_tick;
    led_state_t green_tick;
    logic [7:0] count_mid;
    logic [7:0] count_tick;
    logic       event_ok;

    led_seq_led u_red (
        .state_cur    (red_reg),
        .count_in     (count_reg),
        .blink_divide (blink_divide),
        .state_next   (red_tick),
        .count_out    (count_mid)
    );

    led_seq_led u_green (
        .state_cur    (green_reg),
        .count_in     (count_mid),
        .blink_divide (blink_divide),
        .state_next   (green_tick),
        .count_out    (count_tick)
    );

    assign event_ok = ({1'b0, event_code} < 4'(EVENT_CODES)) || (EVENT_CODES > 8);

    always_comb
    begin
        red_next   = red_reg;
        green_next = green_reg;
        count_next = count_reg;
        if (kind == KIND_TICK)
        begin
            red_next   = red_tick;
            green_next = green_tick;
            count_next = count_tick;
        end
        else if (event_ok)
        begin
            if (green_event == event_code)
            begin
                green_next.pending = new_action;
            end
            if (red_event == event_code)
            begin
                red_next.pending = new_action;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= '{pending: ACT_NONE, level: 1'b0};
            green_reg <= '{pending: ACT_NONE, level: 1'b0};
            count_reg <= 8'd0;
        end
        else if (item_en)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            count_reg <= count_next;
        end
    end

    assign status_cur.green_led   = green_reg.level;
    assign status_cur.red_led     = red_reg.level;
    assign status_cur.green_busy  = (green_reg.pending != ACT_NONE);
    assign status_cur.red_busy    = (red_reg.pending != ACT_NONE);

    assign status_next.green_led  = green_next.level;
    assign status_next.red_led    = red_next.level;
    assign status_next.green_busy = (green_next.pending != ACT_NONE);
    assign status_next.red_busy   = (red_next.pending != ACT_NONE);

endmodule

`default_nettype wire

// ----- dv/led_action_checker.sv -----
`timescale 1ns / 100ps
// Checker for the LED action sequencer: tracks register writes, predicts the LED
// status after every accepted item and compares it with each delivered result.
// Depends on led_seq_pkg.
module led_action_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic [0:0] s_tuser,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    output int         mismatches,
    output int         outstanding
);
    import led_seq_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [2:0]  green_event_sel;
    logic [2:0]  red_event_sel;
    logic [7:0]  blink_divide;
    logic [7:0]  blink_prescale;
    led_state_t  green_state;
    led_state_t  red_state;
    led_status_t expected_status[$];

    initial begin
        mismatches = 0;
        outstanding = 0;
    end

    task automatic advance_led(inout led_state_t led);
        case (led.pending)
            ACT_NONE:
            begin
            end
            ACT_OFF:
            begin
                led.level = 1'b0;
                led.pending = ACT_NONE;
            end
            ACT_ON:
            begin
                led.level = 1'b1;
                led.pending = ACT_NONE;
            end
            ACT_TOGGLE:
            begin
                led.level = ~led.level;
                led.pending = ACT_NONE;
            end
            ACT_PULSE:
            begin
                if (!led.level)
                begin
                    led.level = 1'b1;
                end
                else
                begin
                    led.level = 1'b0;
                    led.pending = ACT_NONE;
                end
            end
            default:
            begin
                if (led.pending >= ACT_BLINK1 && led.pending <= ACT_BLINK8)
                begin
                    blink_prescale = blink_prescale + 8'd1;
                    if (blink_prescale == blink_divide)
                    begin
                        blink_prescale = '0;
                        if (!led.level)
                        begin
                            led.level = 1'b1;
                        end
                        else
                        begin
                            led.level = 1'b0;
                            led.pending = (led.pending == ACT_BLINK1) ? ACT_NONE
                                                                     : led.pending - 4'd1;
                        end
                    end
                end
                else
                begin
                    led.pending = ACT_NONE;
                end
            end
        endcase
    endtask

    function automatic void note_mismatch(led_status_t want, led_status_t got, bit have_want);
        mismatches = mismatches + 1;
        if (mismatches <= REPORT_LIMIT)
        begin
            if (have_want)
                $display("%0t: status mismatch: expected green_led=%0b red_led=%0b green_busy=%0b red_busy=%0b, got green_led=%0b red_led=%0b green_busy=%0b red_busy=%0b",
                         $realtime, want.green_led, want.red_led, want.green_busy,
                         want.red_busy, got.green_led, got.red_led, got.green_busy,
                         got.red_busy);
            else
                $display("%0t: unexpected result: got green_led=%0b red_led=%0b green_busy=%0b red_busy=%0b",
                         $realtime, got.green_led, got.red_led, got.green_busy,
                         got.red_busy);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        led_status_t got;
        led_status_t want;
        if (!rst_n)
        begin
            green_event_sel = '0;
            red_event_sel = '0;
            blink_divide = 8'd1;
            blink_prescale = '0;
            green_state = '{pending: ACT_NONE, level: 1'b0};
            red_state = '{pending: ACT_NONE, level: 1'b0};
            expected_status.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GREEN_EVENT:  green_event_sel = cfg_data[2:0];
                    REG_RED_EVENT:    red_event_sel = cfg_data[2:0];
                    REG_BLINK_DIVIDE: blink_divide = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                got = led_status_t'(m_tdata[3:0]);
                if (expected_status.size() == 0)
                begin
                    note_mismatch(got, got, 1'b0);
                end
                else
                begin
                    want = expected_status.pop_front();
                    if (got.green_led !== want.green_led || got.red_led !== want.red_led ||
                        got.green_busy !== want.green_busy || got.red_busy !== want.red_busy)
                        note_mismatch(want, got, 1'b1);
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == KIND_TICK)
                begin
                    advance_led(red_state);
                    advance_led(green_state);
                end
                else if (int'(s_tdata[2:0]) < EVENT_CODES)
                begin
                    if (green_event_sel == s_tdata[2:0])
                        green_state.pending = s_tdata[6:3];
                    if (red_event_sel == s_tdata[2:0])
                        red_state.pending = s_tdata[6:3];
                end
                want.green_led = green_state.level;
                want.red_led = red_state.level;
                want.green_busy = (green_state.pending != ACT_NONE);
                want.red_busy = (red_state.pending != ACT_NONE);
                expected_status.push_back(want);
            end
            outstanding = expected_status.size();
        end
    end
endmodule

// ----- dv/tb_led_action_sequencer.sv -----
`timescale 1ns / 100ps
// Testbench top for the LED action sequencer: clock, reset, directed and random
// tick and trigger items under varying idle patterns, and the final verdict.
// Depends on led_seq_pkg, led_action_sequencer and led_action_checker.
module tb_led_action_sequencer;
    import led_seq_pkg::*;

    localparam int STALL_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 75;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [2:0] event_code, [6:3] new_action, [7] zero
    logic [0:0] s_tuser;   // [0] kind
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [0] green_led, [1] red_led, [2] green_busy, [3] red_busy
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    int mismatches;
    int outstanding;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int quiet_cycles = 0;
    logic [2:0] green_sel = '0;
    logic [2:0] red_sel = '0;

    led_action_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_action_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(negedge clk)
    begin
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_led_action_sequencer failed");
            $finish;
        end
    end

    // A long hold-off is requested by bumping hold_requests and timed here.
    initial
    begin : result_sink
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Returns at the falling edge after acceptance with the item still offered.
    task automatic send_item(input logic kind, input logic [2:0] ev, input logic [3:0] act);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, act, ev};
        s_tuser <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic tick();
        send_item(KIND_TICK, 3'($urandom), 4'($urandom));
    endtask

    task automatic send_random_item();
        int pick;
        logic [2:0] ev;
        logic [3:0] act;
        pick = $urandom_range(99);
        if (pick < 68)
        begin
            tick();
        end
        else
        begin
            ev = (pick < 80) ? green_sel : ((pick < 92) ? red_sel : 3'($urandom));
            act = ($urandom_range(1) == 1) ? 4'($urandom_range(ACT_BLINK8, ACT_BLINK1))
                                           : 4'($urandom);
            send_item(KIND_TRIGGER, ev, act);
        end
    endtask

    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic configure(input logic [2:0] green_ev, input logic [2:0] red_ev,
                             input logic [7:0] divide);
        logic [7:0] values [3];
        logic [1:0] indexes [3];
        values = '{8'(green_ev), 8'(red_ev), divide};
        indexes = '{REG_GREEN_EVENT, REG_RED_EVENT, REG_BLINK_DIVIDE};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= indexes[i];
            cfg_data <= values[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        green_sel = green_ev;
        red_sel = red_ev;
    endtask

    initial
    begin : stimulus
        logic [2:0] phase_green [PHASES];
        logic [2:0] phase_red [PHASES];
        logic [7:0] phase_divide [PHASES];
        phase_green = '{3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd7, 3'd6, 3'd5};
        phase_red = '{3'd0, 3'd7, 3'd6, 3'd4, 3'd5, 3'd0, 3'd3, 3'd5};
        phase_divide = '{8'd1, 8'd255, 8'd2, 8'd0, 8'd3, 8'd1, 8'd5, 8'd1};

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        configure(3'd3, 3'd5, 8'd1);
        send_item(KIND_TRIGGER, 3'd3, ACT_ON);
        tick();
        send_item(KIND_TRIGGER, 3'd5, ACT_TOGGLE);
        tick();
        send_item(KIND_TRIGGER, 3'd5, ACT_TOGGLE);
        tick();
        send_item(KIND_TRIGGER, 3'd3, ACT_OFF);
        tick();
        send_item(KIND_TRIGGER, 3'd5, ACT_PULSE);
        tick();
        tick();
        send_item(KIND_TRIGGER, 3'd3, 4'hF);
        tick();
        send_item(KIND_TRIGGER, 3'd5, ACT_BLINK1);
        tick();
        tick();
        send_item(KIND_TRIGGER, 3'd3, ACT_BLINK8);
        tick();
        tick();
        send_item(KIND_TRIGGER, 3'd7, ACT_ON);
        send_item(KIND_TRIGGER, 3'd3, ACT_NONE);
        send_item(KIND_TICK, 3'd7, 4'hF);
        send_item(KIND_TRIGGER, 3'd5, 4'd13);
        tick();
        wait_until_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            configure(phase_green[phase], phase_red[phase], phase_divide[phase]);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 48;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 48;
                end
                default:
                begin
                    send_idle_pct = 34;
                    recv_stall_pct = 34;
                end
            endcase
            // The sender keeps offering items through a long output hold-off.
            if (phase == 2)
                hold_requests = hold_requests + 1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_item();
            wait_until_drained();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_led_action_sequencer passed");
        else
            $display("tb_led_action_sequencer failed");
        $finish;
    end
endmodule
